FILE: rtl/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// text console writer assertion macros
// shared property wrappers, sampled on clk and idle while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// condition must hold in every cycle out of reset
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// geometry, character codes, word layouts and address helpers for the
// text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // internal widths
  localparam int CX_W   = $clog2(COLUMNS);
  localparam int CY_W   = $clog2(ROWS);
  localparam int CY1_W  = CY_W + 1;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CELL_W = 16;
  localparam int TAB_W  = $clog2(TAB_SPACES + 1);

  // field widths of the stream words
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int COL_FW  = 7;
  localparam int ROW_FW  = 5;
  localparam int LIN_W   = 11;
  localparam int ATTR_W  = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // control characters
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

  // input word, last field in the low bits
  typedef struct packed {
    logic [3:0]         pad;
    logic [ROW_FW-1:0]  read_row;
    logic [COL_FW-1:0]  read_column;
    logic [COLOR_W-1:0] background;
    logic [COLOR_W-1:0] foreground;
    logic [CHAR_W-1:0]  character;
  } in_word_t;

  // result word, last field in the low bits
  typedef struct packed {
    logic               scrolled;
    logic [ATTR_W-1:0]  cell_attribute;
    logic [CHAR_W-1:0]  cell_character;
    logic [LIN_W-1:0]   cursor_linear;
    logic [ROW_FW-1:0]  cursor_row;
    logic [COL_FW-1:0]  cursor_column;
  } out_word_t;

  // screen memory request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // start address of a physical row
  function automatic logic [ADDR_W-1:0] row_start(input logic [CY_W-1:0] prow);
    return ADDR_W'(prow) * ADDR_W'(COLUMNS);
  endfunction

  // screen row is rotated by the scroll base
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [CY_W-1:0] row,
                                                  input logic [CX_W-1:0] col,
                                                  input logic [CY_W-1:0] base);
    logic [CY1_W-1:0] sum;
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= CY1_W'(ROWS)) begin
      sum = sum - CY1_W'(ROWS);
    end
    return row_start(sum[CY_W-1:0]) + ADDR_W'(col);
  endfunction

endpackage

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console engine: screen store of character and attribute cells
// with a cursor, put, read and clear operations
// ----------------------------------------------------------------------------
// Each input word carries one operation and yields one result word. After
// reset the block zeroes every cell of the screen store before it takes its
// first word. A sequencer steps each operation through the single screen
// memory (one write or one read per cycle, registered read). CR, LF without
// scroll, BS, unused codes and out-of-range reads touch no cell; any other
// character writes one cell, a tab TAB_SPACES cells, a clear all cells; an
// in-range read issues one read. A scroll rotates a row base instead of
// moving data and blanks one row of COLUMNS cells. A new word is taken while
// the previous result still waits on the output side.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input word
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // character[7:0], foreground[11:8], background[15:12], read_column[22:16],
  // read_row[27:23], zero[31:28]
  input  logic [tcw_pkg::IN_DATA_W-1:0]      in_tdata,
  // operation[1:0]
  input  logic [tcw_pkg::OP_W-1:0]           in_tuser,
  // result word
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cursor_column[6:0], cursor_row[11:7], cursor_linear[22:12],
  // cell_character[30:23], cell_attribute[38:31], scrolled[39]
  output logic [tcw_pkg::OUT_DATA_W-1:0]     out_tdata
);

  tcw_pkg::in_word_t           in_word;
  tcw_pkg::out_word_t          out_word;
  tcw_pkg::mem_req_t           mem_req;
  logic [tcw_pkg::CELL_W-1:0]  mem_rdata;

  assign in_word   = tcw_pkg::in_word_t'(in_tdata);
  assign out_tdata = out_word;

  // operation sequencer
  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_word    (in_word),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (out_word),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  // screen store
  tcw_screen_ram u_screen (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

endmodule

FILE: rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// single write port, single read port screen store with registered read
// ----------------------------------------------------------------------------
module tcw_screen_ram (
  input  logic                          clk,
  input  tcw_pkg::mem_req_t             req,
  output logic [tcw_pkg::CELL_W-1:0]    rd_data
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// operation sequencer: cursor, scroll base, fill walker and result register
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module tcw_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcw_pkg::OP_W-1:0]        in_op,
  input  tcw_pkg::in_word_t               in_word,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output tcw_pkg::out_word_t              out_word,
  output tcw_pkg::mem_req_t               mem_req,
  input  logic [tcw_pkg::CELL_W-1:0]      mem_rdata
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_PUT, S_FILL, S_RD, S_RDW, S_DONE
  } state_t;

  state_t                              state_r, state_nxt;
  logic [tcw_pkg::CX_W-1:0]            cur_x_r, cur_x_nxt;
  logic [tcw_pkg::CY_W-1:0]            cur_y_r, cur_y_nxt;
  logic [tcw_pkg::CY_W-1:0]            base_r, base_nxt;
  logic [tcw_pkg::CHAR_W-1:0]          char_r, char_nxt;
  logic [tcw_pkg::ATTR_W-1:0]          attr_r, attr_nxt;
  logic [tcw_pkg::COL_FW-1:0]          rd_col_r, rd_col_nxt;
  logic [tcw_pkg::ROW_FW-1:0]          rd_row_r, rd_row_nxt;
  logic [tcw_pkg::TAB_W-1:0]           tab_left_r, tab_left_nxt;
  logic [tcw_pkg::ADDR_W-1:0]          fill_addr_r, fill_addr_nxt;
  logic [tcw_pkg::ADDR_W-1:0]          fill_last_r, fill_last_nxt;
  logic [tcw_pkg::CELL_W-1:0]          fill_data_r, fill_data_nxt;
  logic [tcw_pkg::CELL_W-1:0]          cell_r, cell_nxt;
  logic                                scrolled_r, scrolled_nxt;
  logic                                out_valid_r, out_valid_nxt;
  tcw_pkg::out_word_t                  out_data_r, out_data_nxt;

  logic                                in_fire;
  logic [tcw_pkg::ATTR_W-1:0]          attr_in;
  logic [tcw_pkg::CY_W-1:0]            base_inc;
  logic [tcw_pkg::ADDR_W-1:0]          scroll_start;
  logic [tcw_pkg::CY_W-1:0]            addr_row;
  logic [tcw_pkg::CX_W-1:0]            addr_col;
  logic [tcw_pkg::ADDR_W-1:0]          cell_addr;
  logic                                rd_in_range;
  logic                                cursor_ok;
  logic                                fill_busy;
  logic                                rd_wait_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign attr_in   = {in_word.background, in_word.foreground};

  // scroll advances the rotation base, the old top row becomes the new bottom row
  assign base_inc     = (base_r == tcw_pkg::CY_W'(tcw_pkg::ROWS - 1)) ? '0
                                                                      : base_r + 1'b1;
  assign scroll_start = tcw_pkg::row_start(base_r);

  assign rd_in_range = (32'(in_word.read_row) < tcw_pkg::ROWS) &&
                       (32'(in_word.read_column) < tcw_pkg::COLUMNS);

  // one shared address path for cell writes and reads
  assign addr_row  = (state_r == S_RD) ? tcw_pkg::CY_W'(rd_row_r) : cur_y_r;
  assign addr_col  = (state_r == S_RD) ? tcw_pkg::CX_W'(rd_col_r) : cur_x_r;
  assign cell_addr = tcw_pkg::phys_addr(addr_row, addr_col, base_r);

  // memory request
  always_comb begin
    mem_req       = '0;
    mem_req.raddr = cell_addr;
    case (state_r)
      S_INIT, S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = fill_addr_r;
        mem_req.wdata = fill_data_r;
      end
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cell_addr;
        mem_req.wdata = {attr_r, char_r};
      end
      S_RD: begin
        mem_req.re = 1'b1;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    base_nxt      = base_r;
    char_nxt      = char_r;
    attr_nxt      = attr_r;
    rd_col_nxt    = rd_col_r;
    rd_row_nxt    = rd_row_r;
    tab_left_nxt  = tab_left_r;
    fill_addr_nxt = fill_addr_r;
    fill_last_nxt = fill_last_r;
    fill_data_nxt = fill_data_r;
    cell_nxt      = cell_r;
    scrolled_nxt  = scrolled_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // result word leaves
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // clear pass after reset
      S_INIT: begin
        fill_addr_nxt = fill_addr_r + 1'b1;
        if (fill_addr_r == fill_last_r) begin
          state_nxt = S_IDLE;
        end
      end

      // decode a new word
      S_IDLE: begin
        if (in_fire) begin
          char_nxt     = in_word.character;
          attr_nxt     = attr_in;
          rd_col_nxt   = in_word.read_column;
          rd_row_nxt   = in_word.read_row;
          cell_nxt     = '0;
          scrolled_nxt = 1'b0;
          tab_left_nxt = '0;
          state_nxt    = S_DONE;
          case (in_op)
            tcw_pkg::OP_PUT: begin
              case (in_word.character)
                tcw_pkg::CHAR_CR: begin
                  cur_x_nxt = '0;
                end
                tcw_pkg::CHAR_LF: begin
                  if (cur_y_r == tcw_pkg::CY_W'(tcw_pkg::ROWS - 1)) begin
                    scrolled_nxt  = 1'b1;
                    base_nxt      = base_inc;
                    fill_addr_nxt = scroll_start;
                    fill_last_nxt = scroll_start + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1);
                    fill_data_nxt = {attr_in, tcw_pkg::CHAR_BLANK};
                    state_nxt     = S_FILL;
                  end else begin
                    cur_y_nxt = cur_y_r + 1'b1;
                  end
                end
                tcw_pkg::CHAR_BS: begin
                  if (cur_x_r != '0) begin
                    cur_x_nxt = cur_x_r - 1'b1;
                  end else if (cur_y_r != '0) begin
                    cur_y_nxt = cur_y_r - 1'b1;
                  end
                end
                tcw_pkg::CHAR_TAB: begin
                  char_nxt     = tcw_pkg::CHAR_BLANK;
                  tab_left_nxt = tcw_pkg::TAB_W'(tcw_pkg::TAB_SPACES);
                  state_nxt    = S_PUT;
                end
                default: begin
                  tab_left_nxt = tcw_pkg::TAB_W'(1);
                  state_nxt    = S_PUT;
                end
              endcase
            end
            tcw_pkg::OP_READ: begin
              if (rd_in_range) begin
                state_nxt = S_RD;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              fill_addr_nxt = '0;
              fill_last_nxt = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
              fill_data_nxt = {attr_in, tcw_pkg::CHAR_BLANK};
              state_nxt     = S_FILL;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // write one cell and advance the cursor
      S_PUT: begin
        tab_left_nxt = tab_left_r - 1'b1;
        state_nxt    = (tab_left_r > tcw_pkg::TAB_W'(1)) ? S_PUT : S_DONE;
        if (cur_x_r == tcw_pkg::CX_W'(tcw_pkg::COLUMNS - 1)) begin
          cur_x_nxt = '0;
          if (cur_y_r == tcw_pkg::CY_W'(tcw_pkg::ROWS - 1)) begin
            scrolled_nxt  = 1'b1;
            base_nxt      = base_inc;
            fill_addr_nxt = scroll_start;
            fill_last_nxt = scroll_start + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1);
            fill_data_nxt = {attr_r, tcw_pkg::CHAR_BLANK};
            state_nxt     = S_FILL;
          end else begin
            cur_y_nxt = cur_y_r + 1'b1;
          end
        end else begin
          cur_x_nxt = cur_x_r + 1'b1;
        end
      end

      // blank a row or the whole screen, then resume a pending tab
      S_FILL: begin
        fill_addr_nxt = fill_addr_r + 1'b1;
        if (fill_addr_r == fill_last_r) begin
          state_nxt = (tab_left_r != '0) ? S_PUT : S_DONE;
        end
      end

      S_RD: begin
        state_nxt = S_RDW;
      end

      S_RDW: begin
        cell_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      // load the result register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.cursor_column    = tcw_pkg::COL_FW'(cur_x_r);
          out_data_nxt.cursor_row       = tcw_pkg::ROW_FW'(cur_y_r);
          out_data_nxt.cursor_linear    = tcw_pkg::LIN_W'(cur_y_r) *
                                          tcw_pkg::LIN_W'(tcw_pkg::COLUMNS) +
                                          tcw_pkg::LIN_W'(cur_x_r);
          out_data_nxt.cell_character   = cell_r[tcw_pkg::CHAR_W-1:0];
          out_data_nxt.cell_attribute   = cell_r[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
          out_data_nxt.scrolled         = scrolled_r;
          state_nxt                     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      base_r      <= '0;
      tab_left_r  <= '0;
      fill_addr_r <= '0;
      fill_last_r <= tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
      fill_data_r <= '0;
      scrolled_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      base_r      <= base_nxt;
      tab_left_r  <= tab_left_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_last_r <= fill_last_nxt;
      fill_data_r <= fill_data_nxt;
      scrolled_r  <= scrolled_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    attr_r     <= attr_nxt;
    rd_col_r   <= rd_col_nxt;
    rd_row_r   <= rd_row_nxt;
    cell_r     <= cell_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_word   = out_data_r;

  // check terms
  assign cursor_ok  = (32'(cur_x_r) < tcw_pkg::COLUMNS) &&
                      (32'(cur_y_r) < tcw_pkg::ROWS) &&
                      (32'(base_r) < tcw_pkg::ROWS);
  assign fill_busy  = (state_r == S_FILL) || (state_r == S_INIT);
  assign rd_wait_ok = (state_r == S_RDW) && !mem_req.we;

  // checks
  `TCW_ASSERT_ALWAYS(a_cursor_range, cursor_ok, "cursor or scroll base out of range")
  `TCW_ASSERT_IMPL(a_fill_bound, fill_busy, fill_addr_r <= fill_last_r, "fill walker overran")
  `TCW_ASSERT_ALWAYS(a_port_excl, !(mem_req.we && mem_req.re), "cell read overlaps a cell write")
  `TCW_ASSERT_NEXT(a_read_done, state_r == S_RD, rd_wait_ok, "read data not taken after the read")

endmodule

FILE: dv/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// drives put, read, clear and unused-code words into the console writer,
// keeps a shadow of the screen store and cursor, and checks each result word
// against it while both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  // operation code with no action, not named in the package
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_WORDS = 1330;
  localparam int DRAIN_CYCLES = 50;
  localparam int REPORT_MAX   = 10;

  // shadow of screen contents and cursor, with the queue of cursor reports
  // still owed by the block
  class console_tracker;
    logic [CELL_W-1:0] screen [CELL_COUNT];
    int unsigned cur_x;
    int unsigned cur_y;
    out_word_t cursor_reports [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned scrolls;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cur_x = 0;
      cur_y = 0;
      mismatches = 0;
      checked = 0;
      scrolls = 0;
    endfunction

    // attribute byte is background in the high nibble, foreground low
    function logic [CELL_W-1:0] pack_cell(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] fg,
                                          logic [COLOR_W-1:0] bg);
      return {bg, fg, ch};
    endfunction

    // move every row up one, bottom row gets the fill cell
    function void scroll_up(logic [CELL_W-1:0] fill);
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = fill;
    endfunction

    function bit line_feed(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
      if (cur_y + 1 >= ROWS) begin
        scroll_up(pack_cell(CHAR_BLANK, fg, bg));
        return 1'b1;
      end
      cur_y++;
      return 1'b0;
    endfunction

    // write at the cursor and advance, wrapping to the next line
    function bit write_glyph(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] fg,
                             logic [COLOR_W-1:0] bg);
      bit wrapped_scroll;
      wrapped_scroll = 1'b0;
      screen[cur_y * COLUMNS + cur_x] = pack_cell(ch, fg, bg);
      if (cur_x + 1 >= COLUMNS) begin
        wrapped_scroll = line_feed(fg, bg);
        cur_x = 0;
      end else begin
        cur_x++;
      end
      return wrapped_scroll;
    endfunction

    // apply one accepted input word and queue the report it owes
    function void note_accepted(logic [OP_W-1:0] op, in_word_t w);
      out_word_t rep;
      logic [CELL_W-1:0] entry;
      bit sc;
      entry = '0;
      sc = 1'b0;
      case (op)
        OP_PUT: begin
          case (w.character)
            CHAR_CR: cur_x = 0;
            CHAR_LF: sc = line_feed(w.foreground, w.background);
            CHAR_BS: begin
              // at column zero go up a row, column stays zero
              if (cur_x > 0) cur_x--;
              else if (cur_y > 0) cur_y--;
            end
            CHAR_TAB: begin
              for (int i = 0; i < TAB_SPACES; i++)
                if (write_glyph(CHAR_BLANK, w.foreground, w.background)) sc = 1'b1;
            end
            default: sc = write_glyph(w.character, w.foreground, w.background);
          endcase
        end
        OP_READ: begin
          // out-of-range coordinates read as an empty cell
          if (w.read_row < ROWS && w.read_column < COLUMNS)
            entry = screen[w.read_row * COLUMNS + w.read_column];
        end
        OP_CLEAR: begin
          foreach (screen[i]) screen[i] = pack_cell(CHAR_BLANK, w.foreground, w.background);
        end
        default: ;
      endcase
      rep.cursor_column  = COL_FW'(cur_x);
      rep.cursor_row     = ROW_FW'(cur_y);
      rep.cursor_linear  = LIN_W'(cur_y * COLUMNS + cur_x);
      rep.cell_character = entry[7:0];
      rep.cell_attribute = entry[15:8];
      rep.scrolled       = sc;
      if (sc) scrolls++;
      cursor_reports.push_back(rep);
    endfunction

    // compare one result word with the oldest owed report
    function void check_report(out_word_t got);
      out_word_t want;
      checked++;
      if (cursor_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: %0t result word %h arrived with nothing outstanding", $time, got);
        return;
      end
      want = cursor_reports.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("ERROR: %0t result %0d mismatch", $time, checked);
          $display("  want col %0d row %0d lin %0d chr %h attr %h scr %0b",
                   want.cursor_column, want.cursor_row, want.cursor_linear,
                   want.cell_character, want.cell_attribute, want.scrolled);
          $display("  got  col %0d row %0d lin %0d chr %h attr %h scr %0b",
                   got.cursor_column, got.cursor_row, got.cursor_linear,
                   got.cell_character, got.cell_attribute, got.scrolled);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // character, foreground, background,
                                         // read_column, read_row, zero pad
  logic [OP_W-1:0] in_tuser = '0;        // operation
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // cursor_column, cursor_row, cursor_linear,
                                         // cell_character, cell_attribute, scrolled

  console_tracker board = new();
  bit steady = 1'b0;   // no idling on either side while set
  int words_sent = 0;
  int clears_sent = 0;

  text_console_writer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic in_word_t word_of(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] fg,
                                       logic [COLOR_W-1:0] bg, logic [COL_FW-1:0] col,
                                       logic [ROW_FW-1:0] row);
    in_word_t w;
    w.pad         = '0;
    w.read_row    = row;
    w.read_column = col;
    w.background  = bg;
    w.foreground  = fg;
    w.character   = ch;
    return w;
  endfunction

  // present one word, hold it until taken, then maybe idle
  task automatic send_word(input logic [OP_W-1:0] op, input in_word_t w);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= op;
    do @(posedge clk); while (in_tready !== 1'b1);
    words_sent++;
    if (op == OP_CLEAR) clears_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side back-pressure
  initial begin
    int stall;
    int burst;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      burst = $urandom_range(1, 12);
      repeat (burst) @(posedge clk);
    end
  end

  // note every accepted word and check every result word
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_accepted(in_tuser, in_tdata);
      if (out_tvalid && out_tready) board.check_report(out_tdata);
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no word moved for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus
  initial begin
    int n;
    int roll;
    int sub;
    int row_pick;
    logic [OP_W-1:0] op;
    in_word_t w;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: store contents after reset, extreme characters and colors
    send_word(OP_READ,  word_of(8'h00, 4'h0, 4'h0, 7'd0, 5'd0));
    send_word(OP_PUT,   word_of(8'h41, 4'hF, 4'h0, 7'd0, 5'd0));
    send_word(OP_PUT,   word_of(8'hFF, 4'h0, 4'hF, 7'd0, 5'd0));
    send_word(OP_PUT,   word_of(8'h00, 4'h5, 4'hA, 7'd0, 5'd0));
    send_word(OP_READ,  word_of(8'h00, 4'h0, 4'h0, 7'd0, 5'd0));
    send_word(OP_READ,  word_of(8'h00, 4'h0, 4'h0, 7'd1, 5'd0));
    send_word(OP_READ,  word_of(8'h00, 4'h0, 4'h0, 7'd2, 5'd0));
    // backspace down to column zero, then once more at the top-left corner
    repeat (4) send_word(OP_PUT, word_of(CHAR_BS, 4'h1, 4'h2, 7'd0, 5'd0));
    send_word(OP_PUT,   word_of(CHAR_TAB, 4'h3, 4'hC, 7'd0, 5'd0));
    send_word(OP_READ,  word_of(8'h00, 4'h0, 4'h0, 7'd3, 5'd0));
    send_word(OP_PUT,   word_of(CHAR_CR, 4'h0, 4'h0, 7'd0, 5'd0));
    send_word(OP_PUT,   word_of(CHAR_LF, 4'h6, 4'h9, 7'd0, 5'd0));
    // backspace at column zero climbs a row
    send_word(OP_PUT,   word_of(CHAR_BS, 4'h0, 4'h0, 7'd0, 5'd0));
    // reads outside the screen, and of the last cell
    send_word(OP_READ,  word_of(8'h00, 4'h0, 4'h0, 7'd0, 5'd25));
    send_word(OP_READ,  word_of(8'hFF, 4'hF, 4'hF, 7'd127, 5'd31));
    send_word(OP_READ,  word_of(8'h00, 4'h0, 4'h0, 7'd80, 5'd0));
    send_word(OP_READ,  word_of(8'h00, 4'h0, 4'h0, 7'd79, 5'd24));
    send_word(OP_NOP,   word_of(8'hA5, 4'hA, 4'h5, 7'd99, 5'd17));
    send_word(OP_CLEAR, word_of(8'h00, 4'h7, 4'h1, 7'd0, 5'd0));
    send_word(OP_READ,  word_of(8'h00, 4'h0, 4'h0, 7'd40, 5'd12));
    send_word(OP_PUT,   word_of(8'h5A, 4'hE, 4'h3, 7'd0, 5'd0));

    // random: mostly text and control characters, reads biased to the
    // rows just written, rare clears and unused codes
    for (n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n % 320) >= 250;
      roll = $urandom_range(0, 999);
      w = word_of(CHAR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 15)),
                  COLOR_W'($urandom_range(0, 15)), COL_FW'($urandom_range(0, 127)),
                  ROW_FW'($urandom_range(0, 31)));
      op = OP_PUT;
      if (roll < 420) begin
        // any byte, control codes included by chance
      end else if (roll < 500) begin
        w.character = CHAR_LF;
      end else if (roll < 550) begin
        w.character = CHAR_CR;
      end else if (roll < 600) begin
        w.character = CHAR_BS;
      end else if (roll < 650) begin
        w.character = CHAR_TAB;
      end else if (roll < 970) begin
        op = OP_READ;
        sub = $urandom_range(0, 9);
        if (sub < 5) begin
          row_pick = int'(board.cur_y) - $urandom_range(0, 2);
          if (row_pick < 0) row_pick = 0;
          w.read_row    = ROW_FW'(row_pick);
          w.read_column = COL_FW'($urandom_range(0, COLUMNS - 1));
        end else if (sub < 9) begin
          w.read_row    = ROW_FW'($urandom_range(0, ROWS - 1));
          w.read_column = COL_FW'($urandom_range(0, COLUMNS - 1));
        end
      end else if (roll < 975) begin
        op = OP_CLEAR;
      end else begin
        op = OP_NOP;
      end
      send_word(op, w);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // drain
    while (board.cursor_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d words sent (%0d clears), %0d results checked, %0d scrolls",
             words_sent, clears_sent, board.checked, board.scrolls);
    $display("run: %0d mismatches", board.mismatches);
    if (board.mismatches == 0 && board.cursor_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
